>>> src/hpbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbf_pkg
// Shared types, constants and the extended Hamming(8,4) code for the packet
// bit framer.
// ----------------------------------------------------------------------------
package hpbf_pkg;

   // Command codes carried in req_tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // Preamble sent ahead of the length byte: AA AA AA AA CC CC
   localparam logic [47:0] PREAMBLE = 48'hAAAA_AAAA_CCCC;

   // Line bits per job
   localparam int unsigned BIT_CNT_W  = 6;
   localparam int unsigned SHIFT_W    = 56;
   localparam logic [BIT_CNT_W-1:0] START_BITS = 6'd56;
   localparam logic [BIT_CNT_W-1:0] DATA_BITS  = 6'd16;

   // Queue depth between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   // One classified job: a start (length byte in the upper half) or a coded
   // data byte (two codewords, high nibble first)
   typedef struct packed {
      logic        is_start;
      logic [15:0] payload;
      logic        ends;
   } job_type;

   // Extended Hamming(8,4) codeword of a nibble
   function automatic logic [7:0] hamming_code(input logic [3:0] nibble);
      logic [7:0] code;
      case (nibble)
         4'h0:    code = 8'h00;
         4'h1:    code = 8'hD2;
         4'h2:    code = 8'h55;
         4'h3:    code = 8'h87;
         4'h4:    code = 8'h99;
         4'h5:    code = 8'h4B;
         4'h6:    code = 8'hCC;
         4'h7:    code = 8'h1E;
         4'h8:    code = 8'hE1;
         4'h9:    code = 8'h33;
         4'hA:    code = 8'hB4;
         4'hB:    code = 8'h66;
         4'hC:    code = 8'h78;
         4'hD:    code = 8'hAA;
         4'hE:    code = 8'h2D;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

endpackage

>>> src/hpbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbf_front
// Accepts input transfers, tracks the open packet and the bytes still due,
// and turns each item into a job for the serializer or drops it.
// ----------------------------------------------------------------------------
module hpbf_front
   import hpbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] packet_length
   input  logic        req_tuser,   // [0] cmd
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic       open_ff, open_in;
   logic [7:0] left_ff, left_in;
   logic       accept;
   logic [7:0] data_byte;
   logic [7:0] packet_length;
   logic [7:0] left_dec;

   assign data_byte     = req_tdata[7:0];
   assign packet_length = req_tdata[15:8];
   assign req_tready    = !q_full;
   assign accept        = req_tvalid && req_tready;
   assign left_dec      = left_ff - 8'd1;

   // Classify the item and update packet state
   always_comb begin
      open_in = open_ff;
      left_in = left_ff;
      q_push  = 1'b0;
      q_job   = '0;
      if (accept) begin
         if (req_tuser == CMD_START) begin
            q_push           = 1'b1;
            q_job.is_start   = 1'b1;
            q_job.payload    = {packet_length, 8'h00};
            q_job.ends       = (packet_length == 8'd0);
            left_in          = packet_length;
            open_in          = (packet_length != 8'd0);
         end else if (open_ff) begin
            q_push           = 1'b1;
            q_job.is_start   = 1'b0;
            q_job.payload    = {hamming_code(data_byte[7:4]), hamming_code(data_byte[3:0])};
            q_job.ends       = (left_dec == 8'd0);
            left_in          = left_dec;
            open_in          = (left_dec != 8'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 8'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
   end

endmodule

>>> src/hpbf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbf_queue
// Two-entry job queue between the classifier and the serializer.
// ----------------------------------------------------------------------------
module hpbf_queue
   import hpbf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type head_job
);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed jobs
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/hpbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbf_back
// Serializer: loads one job into a shift register and sends one line bit
// per cycle while rsp_tready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module hpbf_back
   import hpbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  job_type    q_job,
   output logic       q_pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] line_bit, [7:1] zero
   output logic       rsp_tlast,   // last_of_run
   output logic       rsp_tuser    // [0] packet_end
);

   logic [SHIFT_W-1:0]   shift_ff, shift_in;
   logic [BIT_CNT_W-1:0] bits_ff, bits_in;
   logic                 ends_ff, ends_in;
   logic                 valid_ff, valid_in;
   logic                 bit_ff, bit_in;
   logic                 last_ff, last_in;
   logic                 end_ff, end_in;
   logic                 advance;
   logic                 load;

   assign advance = !valid_ff || rsp_tready;
   assign load    = (bits_ff == '0) || (advance && (bits_ff == BIT_CNT_W'(1)));
   assign q_pop   = load && q_valid;

   // Shift out the current job and load the next one
   always_comb begin
      shift_in = shift_ff;
      bits_in  = bits_ff;
      ends_in  = ends_ff;
      valid_in = valid_ff;
      bit_in   = bit_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      if (advance) begin
         if (bits_ff != '0) begin
            valid_in = 1'b1;
            bit_in   = shift_ff[SHIFT_W-1];
            last_in  = (bits_ff == BIT_CNT_W'(1));
            end_in   = (bits_ff == BIT_CNT_W'(1)) && ends_ff;
            shift_in = {shift_ff[SHIFT_W-2:0], 1'b0};
            bits_in  = bits_ff - BIT_CNT_W'(1);
         end else begin
            valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         ends_in = q_job.ends;
         if (q_job.is_start) begin
            shift_in = {PREAMBLE, q_job.payload[15:8]};
            bits_in  = START_BITS;
         end else begin
            shift_in = {q_job.payload, {(SHIFT_W-16){1'b0}}};
            bits_in  = DATA_BITS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         valid_ff <= valid_in;
      end
      shift_ff <= shift_in;
      ends_ff  <= ends_in;
      bit_ff   <= bit_in;
      last_ff  <= last_in;
      end_ff   <= end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, bit_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = end_ff;

`ifndef SYNTHESIS
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("packet end without run end");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= START_BITS)
      else $error("bit count out of range");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (bits_ff == START_BITS || bits_ff == DATA_BITS))
      else $error("bad bit count after job load");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (bits_ff > BIT_CNT_W'(1)) |-> !q_pop)
      else $error("job popped while serializer busy");
`endif

endmodule

>>> src/hamming_packet_bit_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_packet_bit_framer_unit
// Frames packets into a serial line bit stream with extended Hamming(8,4)
// coding of the payload.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: tuser = cmd (0 start, 1 data), tdata = {packet_length,
//    data_byte}. A start transfer yields 56 line bits (preamble AA AA AA AA
//    CC CC, then the length byte); a data byte of an open packet yields 16
//    bits (codeword of the high nibble, then of the low nibble). Data with
//    no open packet is dropped with no output.
//  - rsp channel: one line bit per transfer in tdata[0]; tlast marks the
//    final bit of each input item, tuser marks the final bit of the packet.
//  - Path: the first line bit passes the queue, the shift register and the
//    output register when the serializer is idle.
//  - Throughput: one line bit per cycle while rsp_tready is high; this is
//    set by the single-bit output serializer. A two-entry job queue lets
//    new items be taken while a job is shifting.
//  - Reset closes any open packet, empties the queue and drops pending bits.
//  - A stalled rsp_tready holds the current bit; the queue then fills and
//    req_tready falls until a slot frees.
// ----------------------------------------------------------------------------
module hamming_packet_bit_framer_unit
   import hpbf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] packet_length
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] line_bit, [7:1] zero
   output logic        rsp_tlast,   // last_of_run
   output logic        rsp_tuser    // [0] packet_end
);

   logic    q_full;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_head_job;

   // Classify incoming transfers
   hpbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_push_job)
   );

   // Decouple classifier and serializer
   hpbf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_job (q_head_job)
   );

   // Serialize jobs onto the line
   hpbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
